// ----- design/ect_pkg.sv -----
// ect_pkg: shared constants, status codes, controller states, datapath
// operations and the command/status/result structs of the ear clipper
// no dependencies
package ect_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int COORD_BITS   = 16;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int PROD_W       = 2 * COORD_BITS + 2;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int AREA_W       = 2 * COORD_BITS + 6;
	localparam int MARGIN_W     = 16;
	localparam int STATUS_W     = 2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_EAR   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

	typedef enum logic [5:0] {
		OP_NOP, OP_LOAD,
		OP_AREA_START, OP_AREA_PREV, OP_AREA_MUL, OP_AREA_ACC,
		OP_RING_INIT, OP_RING_WR,
		OP_PASS_INIT, OP_FIN_INIT,
		OP_RD_PREV, OP_RD_TIP, OP_RD_NEXT, OP_LATCH_N,
		OP_VTX_A, OP_VTX_B, OP_VTX_C,
		OP_MUL_ABC, OP_EVAL_CONVEX,
		OP_K_RD, OP_K_CHK, OP_K_P, OP_D1, OP_D2, OP_D3, OP_DEVAL, OP_K_NEXT,
		OP_NEXT_I,
		OP_EMIT_TRI, OP_RM_INIT, OP_RM_RD, OP_RM_WR, OP_RM_DONE,
		OP_EMIT_FIN, OP_EMIT_OVF, OP_EMIT_FEW, OP_EMIT_NOEAR
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE, S_CHECK,
		S_AR_PREV, S_AR_MUL, S_AR_ACC,
		S_RING_INIT, S_RING_WR,
		S_LOOP_TOP,
		S_E_R0, S_E_R1, S_E_R2, S_E_R3, S_E_V0, S_E_V1, S_E_V2,
		S_MUL_ABC, S_EVAL_CONVEX,
		S_K_RD, S_K_CHK, S_K_P, S_D1, S_D2, S_D3, S_DEVAL, S_K_NEXT,
		S_NEXT_I,
		S_EMIT_EAR, S_RM_INIT, S_RM_RD, S_RM_WR, S_RM_DONE,
		S_EMIT_FIN, S_ST_OVF, S_ST_FEW, S_ST_NOEAR
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic few;
		logic ovf;
		logic area_done;
		logic k_last_n;
		logic k_last_m;
		logic m_is3;
		logic i_last;
		logic convex;
		logic skip;
		logic covered;
		logic busy;
	} stat_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic signed [COORD_BITS-1:0] b_x;
		logic signed [COORD_BITS-1:0] b_y;
		logic signed [COORD_BITS-1:0] c_x;
		logic signed [COORD_BITS-1:0] c_y;
		logic has_triangle;
		logic [STATUS_W-1:0] status;
		logic last_result;
	} result_t;

endpackage

// ----- design/ect_if.sv -----
// ect_if: valid/ready channel interfaces for vertices in and triangles out
// depends on ect_pkg
interface ect_vertex_if;
	logic valid;
	logic ready;
	logic signed [ect_pkg::COORD_BITS-1:0] vertex_x;
	logic signed [ect_pkg::COORD_BITS-1:0] vertex_y;
	logic last_vertex;
	modport source(output valid, vertex_x, vertex_y, last_vertex, input ready);
	modport sink(input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface ect_triangle_if;
	logic valid;
	logic ready;
	logic signed [ect_pkg::COORD_BITS-1:0] corner_a_x;
	logic signed [ect_pkg::COORD_BITS-1:0] corner_a_y;
	logic signed [ect_pkg::COORD_BITS-1:0] corner_b_x;
	logic signed [ect_pkg::COORD_BITS-1:0] corner_b_y;
	logic signed [ect_pkg::COORD_BITS-1:0] corner_c_x;
	logic signed [ect_pkg::COORD_BITS-1:0] corner_c_y;
	logic has_triangle;
	logic [ect_pkg::STATUS_W-1:0] status;
	logic last_result;
	modport source(output valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		corner_c_x, corner_c_y, has_triangle, status, last_result, input ready);
	modport sink(input valid, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
		corner_c_x, corner_c_y, has_triangle, status, last_result, output ready);
endinterface

// ----- design/ect_datapath.sv -----
// ect_datapath: vertex and ring memories, cross product unit, counters and
// the output register; executes one operation per cycle from the controller
// depends on ect_pkg
module ect_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ect_pkg::cmd_t                     cmd,
	input  logic                              cfg_we,
	input  logic [ect_pkg::MARGIN_W-1:0]      cfg_wdata,
	input  logic signed [ect_pkg::COORD_BITS-1:0] in_x,
	input  logic signed [ect_pkg::COORD_BITS-1:0] in_y,
	input  logic                              out_ready,
	output ect_pkg::stat_t                    stat,
	output ect_pkg::result_t                  result,
	output logic                              out_valid
);
	import ect_pkg::*;

	logic signed [COORD_BITS-1:0] xmem [MAX_VERTICES];
	logic signed [COORD_BITS-1:0] ymem [MAX_VERTICES];
	logic [IDX_W-1:0]             ring_mem [MAX_VERTICES];

	logic [CNT_W-1:0]  cnt_q, m_q, k_q;
	logic [IDX_W-1:0]  i_q, i0_q, i1_q, i2_q;
	logic              ovf_q, neg_q, pos_q;
	logic [MARGIN_W-1:0] margin_q;
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, px_q, py_q;
	logic signed [COORD_BITS-1:0] rdx_q, rdy_q;
	logic [IDX_W-1:0]  rring_q;
	logic signed [AREA_W-1:0] area_q;
	logic signed [PROD_W-1:0] mp1_q, mp2_q;
	result_t           res_q, res_d;
	logic              out_valid_q;

	// read / write controls
	logic              v_re, r_re, r_we;
	logic [IDX_W-1:0]  v_raddr, r_raddr, r_waddr, r_wdata;
	logic [CNT_W-1:0]  k_inc, i_inc, rev_idx;

	// cross product operands
	logic signed [COORD_BITS-1:0] p0x, p0y, p1x, p1y, p2x, p2y;
	logic signed [COORD_BITS:0]   m_a1, m_b1, m_a2, m_b2;
	logic signed [PROD_W-1:0]     prod1, prod2;
	logic                         mul_en;
	logic signed [CROSS_W-1:0]    cross_d, margin_pos, margin_neg;
	logic                         dp, dn, emit_any, clear_poly;

	assign k_inc   = k_q + CNT_W'(1);
	assign i_inc   = {1'b0, i_q} + CNT_W'(1);
	assign rev_idx = cnt_q - CNT_W'(1) - k_q;

	always_comb begin
		v_re    = 1'b0;
		v_raddr = '0;
		r_re    = 1'b0;
		r_raddr = '0;
		r_we    = 1'b0;
		r_waddr = k_q[IDX_W-1:0];
		r_wdata = rring_q;
		case (cmd.op)
			OP_AREA_START: begin
				v_re    = 1'b1;
				v_raddr = IDX_W'(cnt_q - CNT_W'(1));
			end
			OP_AREA_PREV: begin
				v_re    = 1'b1;
				v_raddr = k_q[IDX_W-1:0];
			end
			OP_AREA_MUL: begin
				v_re    = 1'b1;
				v_raddr = k_inc[IDX_W-1:0];
			end
			OP_RING_WR: begin
				r_we    = 1'b1;
				r_wdata = area_q[AREA_W-1] ? rev_idx[IDX_W-1:0] : k_q[IDX_W-1:0];
			end
			OP_RD_PREV: begin
				r_re    = 1'b1;
				r_raddr = (i_q == '0) ? IDX_W'(m_q - CNT_W'(1)) : IDX_W'(i_q - IDX_W'(1));
			end
			OP_RD_TIP: begin
				r_re    = 1'b1;
				r_raddr = i_q;
			end
			OP_RD_NEXT: begin
				r_re    = 1'b1;
				r_raddr = (i_inc == m_q) ? '0 : i_inc[IDX_W-1:0];
			end
			OP_LATCH_N: begin
				v_re    = 1'b1;
				v_raddr = i0_q;
			end
			OP_VTX_A: begin
				v_re    = 1'b1;
				v_raddr = i1_q;
			end
			OP_VTX_B: begin
				v_re    = 1'b1;
				v_raddr = i2_q;
			end
			OP_K_RD: begin
				r_re    = 1'b1;
				r_raddr = k_q[IDX_W-1:0];
			end
			OP_K_CHK: begin
				v_re    = 1'b1;
				v_raddr = rring_q;
			end
			OP_RM_RD: begin
				r_re    = 1'b1;
				r_raddr = k_inc[IDX_W-1:0];
			end
			OP_RM_WR: begin
				r_we    = 1'b1;
				r_wdata = rring_q;
			end
			default: begin
			end
		endcase
	end

	// operand select: area terms use a zero origin
	always_comb begin
		p0x    = '0;
		p0y    = '0;
		p1x    = px_q;
		p1y    = py_q;
		p2x    = rdx_q;
		p2y    = rdy_q;
		mul_en = 1'b1;
		case (cmd.op)
			OP_AREA_MUL: begin
			end
			OP_MUL_ABC: begin
				p0x = ax_q; p0y = ay_q; p1x = bx_q; p1y = by_q; p2x = cx_q; p2y = cy_q;
			end
			OP_D1: begin
				p0x = ax_q; p0y = ay_q; p1x = bx_q; p1y = by_q; p2x = px_q; p2y = py_q;
			end
			OP_D2: begin
				p0x = bx_q; p0y = by_q; p1x = cx_q; p1y = cy_q; p2x = px_q; p2y = py_q;
			end
			OP_D3: begin
				p0x = cx_q; p0y = cy_q; p1x = ax_q; p1y = ay_q; p2x = px_q; p2y = py_q;
			end
			default: mul_en = 1'b0;
		endcase
		m_a1 = $signed({p1x[COORD_BITS-1], p1x}) - $signed({p0x[COORD_BITS-1], p0x});
		m_b1 = $signed({p2y[COORD_BITS-1], p2y}) - $signed({p0y[COORD_BITS-1], p0y});
		m_a2 = $signed({p1y[COORD_BITS-1], p1y}) - $signed({p0y[COORD_BITS-1], p0y});
		m_b2 = $signed({p2x[COORD_BITS-1], p2x}) - $signed({p0x[COORD_BITS-1], p0x});
	end

	// full-width signed products of the 17-bit differences
	assign prod1 = m_a1 * m_b1;
	assign prod2 = m_a2 * m_b2;

	assign cross_d    = $signed({mp1_q[PROD_W-1], mp1_q}) - $signed({mp2_q[PROD_W-1], mp2_q});
	assign margin_pos = $signed({{(CROSS_W-MARGIN_W){1'b0}}, margin_q});
	assign margin_neg = -margin_pos;
	assign dp         = cross_d > margin_pos;
	assign dn         = cross_d < margin_neg;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && cnt_q < CNT_W'(MAX_VERTICES)) begin
			xmem[cnt_q[IDX_W-1:0]] <= in_x;
			ymem[cnt_q[IDX_W-1:0]] <= in_y;
		end
		if (v_re) begin
			rdx_q <= xmem[v_raddr];
			rdy_q <= ymem[v_raddr];
		end
		if (r_we) begin
			ring_mem[r_waddr] <= r_wdata;
		end
		if (r_re) begin
			rring_q <= ring_mem[r_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			mp1_q <= prod1;
			mp2_q <= prod2;
		end
		case (cmd.op)
			OP_AREA_START: area_q <= '0;
			OP_AREA_PREV: begin
				px_q <= rdx_q;
				py_q <= rdy_q;
			end
			OP_AREA_MUL: begin
				px_q <= rdx_q;
				py_q <= rdy_q;
			end
			OP_AREA_ACC: area_q <= area_q + {{(AREA_W-CROSS_W){cross_d[CROSS_W-1]}}, cross_d};
			OP_RD_TIP:   i0_q <= rring_q;
			OP_RD_NEXT:  i1_q <= rring_q;
			OP_LATCH_N:  i2_q <= rring_q;
			OP_VTX_A: begin
				ax_q <= rdx_q;
				ay_q <= rdy_q;
			end
			OP_VTX_B: begin
				bx_q <= rdx_q;
				by_q <= rdy_q;
			end
			OP_VTX_C: begin
				cx_q <= rdx_q;
				cy_q <= rdy_q;
			end
			OP_K_P: begin
				px_q <= rdx_q;
				py_q <= rdy_q;
			end
			OP_D2: begin
				neg_q <= dn;
				pos_q <= dp;
			end
			OP_D3: begin
				neg_q <= neg_q | dn;
				pos_q <= pos_q | dp;
			end
			default: begin
			end
		endcase
	end

	assign emit_any   = (cmd.op == OP_EMIT_TRI) || (cmd.op == OP_EMIT_FIN) ||
		(cmd.op == OP_EMIT_OVF) || (cmd.op == OP_EMIT_FEW) || (cmd.op == OP_EMIT_NOEAR);
	assign clear_poly = emit_any && (cmd.op != OP_EMIT_TRI);

	// next result: triangle corners or a status word with zero corners
	always_comb begin
		res_d             = '0;
		res_d.last_result = 1'b1;
		case (cmd.op)
			OP_EMIT_TRI, OP_EMIT_FIN: begin
				res_d.a_x          = ax_q;
				res_d.a_y          = ay_q;
				res_d.b_x          = bx_q;
				res_d.b_y          = by_q;
				res_d.c_x          = cx_q;
				res_d.c_y          = cy_q;
				res_d.has_triangle = 1'b1;
				res_d.status       = ST_OK;
				res_d.last_result  = (cmd.op == OP_EMIT_FIN);
			end
			OP_EMIT_OVF:   res_d.status = ST_OVERFLOW;
			OP_EMIT_FEW:   res_d.status = ST_TOO_FEW;
			OP_EMIT_NOEAR: res_d.status = ST_NO_EAR;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit_any) begin
			res_q <= res_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			m_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
			margin_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			if (emit_any) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (clear_poly) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				m_q   <= '0;
			end
			case (cmd.op)
				OP_LOAD: begin
					if (cnt_q < CNT_W'(MAX_VERTICES)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				OP_AREA_START: k_q <= '0;
				OP_AREA_MUL:   k_q <= k_inc;
				OP_RING_INIT: begin
					k_q <= '0;
					m_q <= cnt_q;
				end
				OP_RING_WR:     k_q <= k_inc;
				OP_PASS_INIT:   i_q <= '0;
				OP_FIN_INIT:    i_q <= IDX_W'(1);
				OP_EVAL_CONVEX: k_q <= '0;
				OP_K_NEXT:      k_q <= k_inc;
				OP_NEXT_I:      i_q <= i_inc[IDX_W-1:0];
				OP_RM_INIT:     k_q <= {1'b0, i_q};
				OP_RM_WR:       k_q <= k_inc;
				OP_RM_DONE:     m_q <= m_q - CNT_W'(1);
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat.few       = cnt_q < CNT_W'(3);
		stat.ovf       = ovf_q;
		stat.area_done = k_q == cnt_q;
		stat.k_last_n  = k_inc == cnt_q;
		stat.k_last_m  = k_inc == m_q;
		stat.m_is3     = m_q == CNT_W'(3);
		stat.i_last    = i_inc == m_q;
		stat.convex    = dp;
		stat.skip      = (rring_q == i0_q) || (rring_q == i1_q) || (rring_q == i2_q);
		stat.covered   = !((neg_q | dn) && (pos_q | dp));
		stat.busy      = out_valid_q;
	end

	assign result    = res_q;
	assign out_valid = out_valid_q;

endmodule

// ----- design/ect_ctrl.sv -----
// ect_ctrl: sequencer for loading, orientation, ring build, ear search and clipping
// depends on ect_pkg
module ect_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_accept,
	input  logic           in_last,
	input  ect_pkg::stat_t stat,
	output logic           in_ready,
	output ect_pkg::cmd_t  cmd
);
	import ect_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:        if (in_accept && in_last) state_nxt = S_CHECK;
			S_CHECK: begin
				if (stat.ovf)      state_nxt = S_ST_OVF;
				else if (stat.few) state_nxt = S_ST_FEW;
				else               state_nxt = S_AR_PREV;
			end
			S_AR_PREV:     state_nxt = S_AR_MUL;
			S_AR_MUL:      state_nxt = S_AR_ACC;
			S_AR_ACC:      state_nxt = stat.area_done ? S_RING_INIT : S_AR_MUL;
			S_RING_INIT:   state_nxt = S_RING_WR;
			S_RING_WR:     if (stat.k_last_n) state_nxt = S_LOOP_TOP;
			S_LOOP_TOP:    state_nxt = S_E_R0;
			S_E_R0:        state_nxt = S_E_R1;
			S_E_R1:        state_nxt = S_E_R2;
			S_E_R2:        state_nxt = S_E_R3;
			S_E_R3:        state_nxt = S_E_V0;
			S_E_V0:        state_nxt = S_E_V1;
			S_E_V1:        state_nxt = S_E_V2;
			S_E_V2:        state_nxt = stat.m_is3 ? S_EMIT_FIN : S_MUL_ABC;
			S_MUL_ABC:     state_nxt = S_EVAL_CONVEX;
			S_EVAL_CONVEX: state_nxt = stat.convex ? S_K_RD : S_NEXT_I;
			S_K_RD:        state_nxt = S_K_CHK;
			S_K_CHK:       state_nxt = stat.skip ? S_K_NEXT : S_K_P;
			S_K_P:         state_nxt = S_D1;
			S_D1:          state_nxt = S_D2;
			S_D2:          state_nxt = S_D3;
			S_D3:          state_nxt = S_DEVAL;
			S_DEVAL:       state_nxt = stat.covered ? S_NEXT_I : S_K_NEXT;
			S_K_NEXT:      state_nxt = stat.k_last_m ? S_EMIT_EAR : S_K_RD;
			S_NEXT_I:      state_nxt = stat.i_last ? S_ST_NOEAR : S_E_R0;
			S_EMIT_EAR:    if (!stat.busy) state_nxt = S_RM_INIT;
			S_RM_INIT:     state_nxt = S_RM_RD;
			S_RM_RD:       state_nxt = stat.k_last_m ? S_RM_DONE : S_RM_WR;
			S_RM_WR:       state_nxt = S_RM_RD;
			S_RM_DONE:     state_nxt = S_LOOP_TOP;
			S_EMIT_FIN, S_ST_OVF, S_ST_FEW, S_ST_NOEAR: begin
				if (!stat.busy) state_nxt = S_IDLE;
			end
			default:       state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NOP;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_accept) cmd.op = OP_LOAD;
			end
			S_CHECK:       if (!stat.ovf && !stat.few) cmd.op = OP_AREA_START;
			S_AR_PREV:     cmd.op = OP_AREA_PREV;
			S_AR_MUL:      cmd.op = OP_AREA_MUL;
			S_AR_ACC:      cmd.op = OP_AREA_ACC;
			S_RING_INIT:   cmd.op = OP_RING_INIT;
			S_RING_WR:     cmd.op = OP_RING_WR;
			S_LOOP_TOP:    cmd.op = stat.m_is3 ? OP_FIN_INIT : OP_PASS_INIT;
			S_E_R0:        cmd.op = OP_RD_PREV;
			S_E_R1:        cmd.op = OP_RD_TIP;
			S_E_R2:        cmd.op = OP_RD_NEXT;
			S_E_R3:        cmd.op = OP_LATCH_N;
			S_E_V0:        cmd.op = OP_VTX_A;
			S_E_V1:        cmd.op = OP_VTX_B;
			S_E_V2:        cmd.op = OP_VTX_C;
			S_MUL_ABC:     cmd.op = OP_MUL_ABC;
			S_EVAL_CONVEX: cmd.op = OP_EVAL_CONVEX;
			S_K_RD:        cmd.op = OP_K_RD;
			S_K_CHK:       cmd.op = OP_K_CHK;
			S_K_P:         cmd.op = OP_K_P;
			S_D1:          cmd.op = OP_D1;
			S_D2:          cmd.op = OP_D2;
			S_D3:          cmd.op = OP_D3;
			S_DEVAL:       cmd.op = OP_DEVAL;
			S_K_NEXT:      cmd.op = OP_K_NEXT;
			S_NEXT_I:      cmd.op = OP_NEXT_I;
			S_EMIT_EAR:    if (!stat.busy) cmd.op = OP_EMIT_TRI;
			S_RM_INIT:     cmd.op = OP_RM_INIT;
			S_RM_RD:       if (!stat.k_last_m) cmd.op = OP_RM_RD;
			S_RM_WR:       cmd.op = OP_RM_WR;
			S_RM_DONE:     cmd.op = OP_RM_DONE;
			S_EMIT_FIN:    if (!stat.busy) cmd.op = OP_EMIT_FIN;
			S_ST_OVF:      if (!stat.busy) cmd.op = OP_EMIT_OVF;
			S_ST_FEW:      if (!stat.busy) cmd.op = OP_EMIT_FEW;
			S_ST_NOEAR:    if (!stat.busy) cmd.op = OP_EMIT_NOEAR;
			default:       cmd.op = OP_NOP;
		endcase
	end

endmodule

// ----- design/ear_clip_triangulator.sv -----
// ear_clip_triangulator: top level, controller plus datapath; uses ect_pkg, ect_if, ect_ctrl, ect_datapath
// sequence: the last vertex starts the orientation sum and then the ring build; each pass then
// checks ear candidates for convexity and tests them against every ring vertex (corners of the
// candidate are skipped); clipping shifts the ring entries after the tip down by one
// throughput: one polygon at a time, vertices one per cycle while loading; a result waits for the last
// reset: counters, margin and output valid clear; memories keep their contents
module ear_clip_triangulator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ect_pkg::MARGIN_W-1:0] cfg_wdata,
	ect_vertex_if.sink                 vertex_in,
	ect_triangle_if.source             triangle_out
);
	import ect_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	result_t result;
	logic    in_ready;
	logic    in_accept;

	// a vertex transaction completes on valid and ready
	assign in_accept       = vertex_in.valid && in_ready;
	assign vertex_in.ready = in_ready;

	// sequencer: load, orientation sum, ring build, ear search, clipping
	ect_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_last   (vertex_in.last_vertex),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// memories, cross product unit and result register
	ect_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_x      (vertex_in.vertex_x),
		.in_y      (vertex_in.vertex_y),
		.out_ready (triangle_out.ready),
		.stat      (stat),
		.result    (result),
		.out_valid (triangle_out.valid)
	);

	// result register fans out to the output channel fields
	assign triangle_out.corner_a_x   = result.a_x;
	assign triangle_out.corner_a_y   = result.a_y;
	assign triangle_out.corner_b_x   = result.b_x;
	assign triangle_out.corner_b_y   = result.b_y;
	assign triangle_out.corner_c_x   = result.c_x;
	assign triangle_out.corner_c_y   = result.c_y;
	assign triangle_out.has_triangle = result.has_triangle;
	assign triangle_out.status       = result.status;
	assign triangle_out.last_result  = result.last_result;

endmodule
